// File: src/packet_jitter_reorder_buffer_assert.svh
// Assertion macros for the packet jitter reorder buffer.
// Used by the top level; depends on nothing.
`ifndef PACKET_JITTER_REORDER_BUFFER_ASSERT_SVH
`define PACKET_JITTER_REORDER_BUFFER_ASSERT_SVH
// Property that holds in the cycle after a condition.
`define PJRB_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
// Property that holds in the same cycle as a condition.
`define PJRB_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
`endif

// File: src/pjrb_pkg.sv
// Package for the packet jitter reorder buffer: types and constants.
// Used by pjrb_out_reg and the top level; depends on nothing.
package pjrb_pkg;
	localparam int SLOTS_DEF = 8;
	localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;
	localparam logic [15:0] TICKS_RESET = 16'd100;
	localparam logic [3:0] FCNT_MAX = 4'd15;
	localparam logic [15:0] REC_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_PLAY    = 2'd0,
		KIND_SILENCE = 2'd1,
		KIND_DISCARD = 2'd2
	} kind_t;

	typedef enum logic {
		REG_RECOVER_TRAILING = 1'b0,
		REG_BUFFER_TICKS     = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PKT,
		ST_DRAIN_RD,
		ST_DRAIN,
		ST_PLACE,
		ST_DISC
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tag;
		logic [15:0] len;
		logic [15:0] rec;
		logic        last;
	} result_t;
endpackage

// File: src/pjrb_ram.sv
// Generic single-port-write, single-read RAM with a registered read port.
// Depends on nothing.
module pjrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/pjrb_out_reg.sv
// Output register stage for result words, decoupling the result stream.
// Depends on pjrb_pkg.
module pjrb_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pjrb_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pjrb_pkg::result_t out_data
);
	import pjrb_pkg::*;

	logic valid_q;
	result_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end
endmodule

// File: src/packet_jitter_reorder_buffer.sv
// Top level of the packet jitter reorder buffer: control sequencer, slot RAM, output register.
// Depends on pjrb_pkg, pjrb_ram, pjrb_out_reg and the assertion header.
//
// Channel   Dir  Words
// s_axis    in   tdata: seq_num, buf_tag, buf_len, device_queue; tuser: mode
// m_axis    out  tdata: out_tag, out_len, recovered_count; tuser: kind; tlast: last
// cfg       in   index 0 recover_trailing, 1 buffer_ticks
//
// A word that is dropped, stored or is a tick without expiry passes through accept and decide.
// A duplicate adds the discard state for its discard word.
// A drain of n slots passes through accept, decide, one RAM read, n words and placement.
// Discard and drain words stall while the output register is full and not taken.
// Reset clears all control state; slot RAM contents are guarded by full bits.
// Configuration is taken only while idle, ahead of an input word in the same cycle.
module packet_jitter_reorder_buffer #(
	parameter int SLOTS = pjrb_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata, // seq_num, buf_tag, buf_len, device_queue
	input  logic        s_axis_tuser, // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata, // out_tag, out_len, recovered_count
	output logic [1:0]  m_axis_tuser, // kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import pjrb_pkg::*;

	`include "packet_jitter_reorder_buffer_assert.svh"

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int HALF = SLOTS / 2;
	localparam logic signed [17:0] SLOTS_S = 18'(SLOTS);
	localparam logic signed [17:0] HALF_S = 18'(HALF);

	state_t state_q, state_d;
	logic rtrail_q;
	logic [15:0] ticks_q;
	logic [SLOTS-1:0] full_q, full_d;
	logic signed [17:0] base_q, base_d, lps_q, lps_d;
	logic filling_q, filling_d;
	logic [3:0] fcnt_q, fcnt_d;
	logic [CW-1:0] tdepth_q, tdepth_d;
	logic [23:0] timer_q, timer_d;
	logic trun_q, trun_d;
	logic [15:0] rec_q, rec_d;
	logic [CW-1:0] idx_q, idx_d, dlim_q, dlim_d;
	logic from_tick_q, from_tick_d;
	logic ns_small_q, ns_small_d;
	logic mode_q;
	logic [15:0] seq_q, len_q;
	logic [7:0] tag_q, dq_q;

	function automatic logic [23:0] sat24(input logic [24:0] v);
		return (v > 25'(TIMER_MAX)) ? TIMER_MAX : v[23:0];
	endfunction

	// RAM for tag and length of every slot.
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [23:0] ram_rdata;
	pjrb_ram #(.WIDTH(24), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata({tag_q, len_q}),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic res_valid, res_ready;
	result_t res;
	result_t od;
	pjrb_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .in_valid(res_valid), .in_ready(res_ready),
		.in_data(res), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
	);
	assign m_axis_tdata = {od.rec, od.len, od.tag};
	assign m_axis_tuser = od.kind;
	assign m_axis_tlast = od.last;

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;

	// Classification of the captured word.
	logic [CW-1:0] depth_c, win_c, more_c, trim_c, idx_next_c;
	logic signed [17:0] seq_s, base_eff, off0, off_r, lps_plus1, win_s;
	logic restart, use_lps, drain_last;
	logic [23:0] ext_c, load_full_c, load_half_c;

	assign depth_c = (tdepth_q > CW'(SLOTS)) ? CW'(SLOTS) : tdepth_q;
	assign restart = !mode_q && !filling_q && (dq_q <= 8'd1);
	assign use_lps = restart && (fcnt_q == '0);
	assign win_c = restart ? CW'(SLOTS) : depth_c;
	assign win_s = signed'(18'(win_c));
	assign more_c = CW'(SLOTS) - depth_c;
	assign seq_s = signed'({2'b00, seq_q});
	assign base_eff = (base_q == -18'sd1) ? seq_s : base_q;
	assign off0 = seq_s - base_eff;
	assign lps_plus1 = lps_q + 18'sd1;
	assign off_r = seq_s - lps_plus1;
	assign ext_c = sat24({1'b0, timer_q} + 25'(ticks_q) * 25'(more_c));
	assign load_full_c = sat24(25'(ticks_q) * 25'(SLOTS));
	assign load_half_c = sat24(25'(ticks_q) * 25'(HALF));
	assign idx_next_c = idx_q + CW'(1);
	assign drain_last = (idx_next_c == dlim_q);

	// Trimmed drain limit: highest full slot inside the window, plus one.
	always_comb begin
		trim_c = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (CW'(i) < win_c && full_q[i]) begin
				trim_c = CW'(i + 1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		full_d = full_q;
		base_d = base_q;
		lps_d = lps_q;
		filling_d = filling_q;
		fcnt_d = fcnt_q;
		tdepth_d = tdepth_q;
		timer_d = timer_q;
		trun_d = trun_q;
		rec_d = rec_q;
		idx_d = idx_q;
		dlim_d = dlim_q;
		from_tick_d = from_tick_q;
		ns_small_d = ns_small_q;
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_raddr = idx_q[AW-1:0];
		res_valid = 1'b0;
		res.kind = KIND_SILENCE;
		res.tag = '0;
		res.len = '0;
		res.rec = rec_q;
		res.last = 1'b0;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = ST_PKT;
			ST_PKT: begin
				state_d = ST_IDLE;
				if (mode_q) begin
					if (trun_q) begin
						if (timer_q <= 24'd1) begin
							timer_d = '0;
							trun_d = 1'b0;
							if (fcnt_q != '0) begin
								from_tick_d = 1'b1;
								idx_d = '0;
								dlim_d = rtrail_q ? depth_c : trim_c;
								state_d = ((rtrail_q ? depth_c : trim_c) != '0) ?
									ST_DRAIN_RD : ST_PLACE;
							end
						end else begin
							timer_d = timer_q - 24'd1;
						end
					end
				end else begin
					base_d = base_eff;
					if (off0 >= 18'sd0) begin
						if (restart) begin
							filling_d = 1'b1;
							tdepth_d = CW'(SLOTS);
							timer_d = trun_q ? ext_c : load_full_c;
							trun_d = 1'b1;
						end
						if (use_lps) begin
							base_d = lps_plus1;
							if (off_r >= 18'sd0) begin
								ram_we = 1'b1;
								fcnt_d = 4'd1;
								if (off_r < SLOTS_S) begin
									ram_waddr = off_r[AW-1:0];
									full_d[off_r[AW-1:0]] = 1'b1;
								end else begin
									base_d = seq_s;
									full_d[0] = 1'b1;
								end
							end
						end else if (off0 < win_s) begin
							if (!full_q[off0[AW-1:0]]) begin
								ram_we = 1'b1;
								ram_waddr = off0[AW-1:0];
								full_d[off0[AW-1:0]] = 1'b1;
								if (fcnt_q != FCNT_MAX) fcnt_d = fcnt_q + 4'd1;
								if (seq_s <= lps_q && rec_q != REC_MAX) rec_d = rec_q + 16'd1;
							end else begin
								state_d = ST_DISC;
							end
						end else begin
							from_tick_d = 1'b0;
							idx_d = '0;
							dlim_d = rtrail_q ? win_c : trim_c;
							ns_small_d = (off0 - win_s) < HALF_S;
							state_d = ((rtrail_q ? win_c : trim_c) != '0) ? ST_DRAIN_RD : ST_PLACE;
						end
					end
				end
			end
			ST_DRAIN_RD: state_d = ST_DRAIN;
			ST_DRAIN: begin
				res_valid = 1'b1;
				if (full_q[idx_q[AW-1:0]]) begin
					res.kind = KIND_PLAY;
					res.tag = ram_rdata[23:16];
					res.len = ram_rdata[15:0];
				end
				res.last = drain_last;
				if (res_ready) begin
					if (full_q[idx_q[AW-1:0]]) begin
						full_d[idx_q[AW-1:0]] = 1'b0;
						lps_d = base_q + signed'(18'(idx_q));
					end else if (!rtrail_q) begin
						lps_d = base_q + signed'(18'(idx_q));
					end
					idx_d = idx_next_c;
					ram_raddr = idx_next_c[AW-1:0];
					if (drain_last) state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				state_d = ST_IDLE;
				filling_d = 1'b0;
				tdepth_d = CW'(HALF);
				timer_d = load_half_c;
				trun_d = 1'b1;
				if (from_tick_q) begin
					fcnt_d = '0;
					base_d = lps_plus1;
				end else begin
					ram_we = 1'b1;
					if (ns_small_q && off_r >= 18'sd0 && off_r < HALF_S) begin
						base_d = lps_plus1;
						ram_waddr = off_r[AW-1:0];
						full_d[off_r[AW-1:0]] = 1'b1;
						fcnt_d = 4'(off_r + 18'sd1);
					end else begin
						base_d = seq_s;
						full_d[0] = 1'b1;
						if (ns_small_q && off_r >= 18'sd0) begin
							fcnt_d = (off_r > 18'sd14) ? FCNT_MAX : 4'(off_r + 18'sd1);
						end else begin
							fcnt_d = 4'd1;
						end
					end
				end
			end
			ST_DISC: begin
				res_valid = 1'b1;
				res.kind = KIND_DISCARD;
				res.tag = tag_q;
				res.len = len_q;
				res.last = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			full_q <= '0;
			base_q <= -18'sd1;
			lps_q <= -18'sd1;
			filling_q <= 1'b0;
			fcnt_q <= '0;
			tdepth_q <= CW'(SLOTS);
			timer_q <= '0;
			trun_q <= 1'b0;
			rec_q <= '0;
			idx_q <= '0;
			dlim_q <= '0;
			from_tick_q <= 1'b0;
			ns_small_q <= 1'b0;
		end else begin
			state_q <= state_d;
			full_q <= full_d;
			base_q <= base_d;
			lps_q <= lps_d;
			filling_q <= filling_d;
			fcnt_q <= fcnt_d;
			tdepth_q <= tdepth_d;
			timer_q <= timer_d;
			trun_q <= trun_d;
			rec_q <= rec_d;
			idx_q <= idx_d;
			dlim_q <= dlim_d;
			from_tick_q <= from_tick_d;
			ns_small_q <= ns_small_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtrail_q <= 1'b0;
			ticks_q <= TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RECOVER_TRAILING: rtrail_q <= cfg_data[0];
				REG_BUFFER_TICKS: ticks_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_q <= s_axis_tuser;
			seq_q <= s_axis_tdata[15:0];
			tag_q <= s_axis_tdata[23:16];
			len_q <= s_axis_tdata[39:24];
			dq_q <= s_axis_tdata[47:40];
		end
	end

	`PJRB_ASSERT_NOW(a_out_kind, m_axis_tvalid, m_axis_tuser <= KIND_DISCARD)
	`PJRB_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready)
	`PJRB_ASSERT_NEXT(a_accept_decide, s_axis_tvalid && s_axis_tready, state_q == ST_PKT)
	`PJRB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule
